[rtl/multi_device_copy_coherency_directory_core_macros.svh]
// Assertion macros shared by the coherency directory RTL.
`ifndef MULTI_DEVICE_COPY_COHERENCY_DIRECTORY_CORE_MACROS_SVH
`define MULTI_DEVICE_COPY_COHERENCY_DIRECTORY_CORE_MACROS_SVH

// Check that a condition implies an expression in the same cycle.
`define MDCCD_ASSERT_IMP(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("coherency directory assertion failed");

// Check that a condition implies an expression in the next cycle.
`define MDCCD_ASSERT_NXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("coherency directory assertion failed");

`endif

[rtl/mdccd_pkg.sv]
// Shared types, codes and sizes of the coherency directory.
package mdccd_pkg;

    localparam int DEVICES = 8;
    localparam int DEV_W   = (DEVICES > 1) ? $clog2(DEVICES) : 1;

    localparam int ACT_W   = 3;
    localparam int DEVF_W  = 3;
    localparam int VER_W   = 32;
    localparam int RC_W    = 16;
    localparam int ST_W    = 2;
    localparam int STAT_W  = 2;
    localparam int OWNER_W = 4;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ATTACH  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DETACH  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET_VER = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ACQUIRE = 3'd4;

    // Coherency states
    localparam logic [ST_W-1:0] CS_INVALID   = 2'd0;
    localparam logic [ST_W-1:0] CS_SHARED    = 2'd1;
    localparam logic [ST_W-1:0] CS_EXCLUSIVE = 2'd2;
    localparam logic [ST_W-1:0] CS_OWNED     = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BUSY      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_COPY   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_SOURCE = 2'd3;

    // Unsigned all-ones "none" value for owner and source slot
    localparam logic [OWNER_W-1:0] SLOT_NONE = 4'hF;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [DEVF_W-1:0] device;
        logic              want_read;
        logic              want_write;
        logic [VER_W-1:0]  new_version;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               transfer_needed;
        logic [OWNER_W-1:0] source_device;
        logic [ST_W-1:0]    device_state;
        logic [OWNER_W-1:0] owner;
    } t_result;

    typedef struct packed {
        logic capture;
        logic compare;
        logic commit;
    } t_dp_cmd;

endpackage

[rtl/mdccd_ctrl.sv]
// Sequencing controller: capture, version compare, commit and output handshake.
`include "multi_device_copy_coherency_directory_core_macros.svh"

module mdccd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mdccd_pkg::t_dp_cmd o_cmd
);
    import mdccd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Step through the phases of one transaction
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result until the sink takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `MDCCD_ASSERT_IMP(a_one_cmd, 1'b1, ($onehot0({o_cmd.capture, o_cmd.compare, o_cmd.commit})))
    `MDCCD_ASSERT_NXT(a_cap_then_cmp, o_cmd.capture, o_cmd.compare)
    `MDCCD_ASSERT_IMP(a_commit_free, o_cmd.commit, (!r_out_valid || i_out_ready))
    `MDCCD_ASSERT_NXT(a_commit_shows, o_cmd.commit, r_out_valid)

endmodule

[rtl/mdccd_dp.sv]
// Directory datapath: slot registers, version compares, action logic, result register.
`include "multi_device_copy_coherency_directory_core_macros.svh"

module mdccd_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mdccd_pkg::t_dp_cmd i_cmd,
    input  mdccd_pkg::t_item   i_item,
    output mdccd_pkg::t_result o_result
);
    import mdccd_pkg::*;

    // Directory entry
    logic [DEVICES-1:0] r_present, n_present;
    logic [ST_W-1:0]    r_state   [DEVICES];
    logic [ST_W-1:0]    n_state   [DEVICES];
    logic [VER_W-1:0]   r_version [DEVICES];
    logic [VER_W-1:0]   n_version [DEVICES];
    logic [RC_W-1:0]    r_readers [DEVICES];
    logic [RC_W-1:0]    n_readers [DEVICES];
    logic [OWNER_W-1:0] r_owner, n_owner;

    // Held transaction and compare flags
    t_item              r_item;
    logic [DEVICES-1:0] r_newer, r_older;
    logic [DEVICES-1:0] n_newer, n_older;
    t_result            r_result, n_result;

    logic [DEVICES-1:0] sel;
    logic               in_range;
    logic               my_present;
    logic [ST_W-1:0]    my_state;
    logic [VER_W-1:0]   my_ver;

    // Decode the addressed slot
    always_comb begin
        in_range   = (int'(r_item.device) < DEVICES);
        my_present = 1'b0;
        my_state   = CS_INVALID;
        my_ver     = '0;
        for (int i = 0; i < DEVICES; i++) begin
            sel[i] = (int'(r_item.device) == i);
            if (sel[i]) begin
                my_present = r_present[i];
                my_state   = r_state[i];
                my_ver     = r_version[i];
            end
        end
    end

    // Compare every slot version with the addressed one
    always_comb begin
        for (int i = 0; i < DEVICES; i++) begin
            n_newer[i] = (r_version[i] > my_ver);
            n_older[i] = (r_version[i] < my_ver);
        end
    end

    // Apply the action
    always_comb begin
        logic [ST_W-1:0]    s;
        logic [OWNER_W-1:0] valid;
        logic               xfer;
        logic               drop_owner;
        logic [DEVICES-1:0] osel;

        n_present  = r_present;
        n_state    = r_state;
        n_version  = r_version;
        n_readers  = r_readers;
        n_owner    = r_owner;
        n_result   = '0;
        n_result.source_device = SLOT_NONE;
        s          = CS_INVALID;
        valid      = r_owner;
        xfer       = 1'b0;
        drop_owner = 1'b0;
        osel       = in_range ? sel : '0;

        unique case (r_item.action)
            ACT_CREATE: begin
                osel    = '0;
                osel[0] = 1'b1;
                if (r_present == '0) begin
                    n_present[0] = 1'b1;
                    n_state[0]   = CS_OWNED;
                    n_version[0] = '0;
                    n_readers[0] = '0;
                    n_owner      = '0;
                end else if (!r_present[0]) begin
                    n_present[0] = 1'b1;
                    n_state[0]   = CS_INVALID;
                    n_version[0] = '0;
                    n_readers[0] = '0;
                end
            end
            ACT_ATTACH: begin
                if (!in_range) begin
                    n_result.status = STAT_NO_COPY;
                end else if (my_present) begin
                    n_result.status = STAT_BUSY;
                end else begin
                    for (int i = 0; i < DEVICES; i++) begin
                        if (sel[i]) begin
                            n_present[i] = 1'b1;
                            n_state[i]   = CS_INVALID;
                            n_version[i] = '0;
                            n_readers[i] = '0;
                        end
                    end
                end
            end
            ACT_DETACH: begin
                if (!in_range || !my_present) begin
                    n_result.status = STAT_NO_COPY;
                end else begin
                    for (int i = 0; i < DEVICES; i++) begin
                        if (sel[i]) begin
                            n_present[i] = 1'b0;
                            n_state[i]   = CS_INVALID;
                            n_version[i] = '0;
                            n_readers[i] = '0;
                        end
                    end
                    if (r_owner == {1'b0, r_item.device}) begin
                        n_owner = SLOT_NONE;
                    end
                end
            end
            ACT_SET_VER: begin
                if (!in_range || !my_present) begin
                    n_result.status = STAT_NO_COPY;
                end else begin
                    for (int i = 0; i < DEVICES; i++) begin
                        if (sel[i]) begin
                            n_version[i] = r_item.new_version;
                        end
                    end
                end
            end
            ACT_ACQUIRE: begin
                if (!in_range || !my_present) begin
                    n_result.status = STAT_NO_COPY;
                end else begin
                    // Find the transfer source: the owner if any, else the last match in slot order
                    if (my_state == CS_INVALID) begin
                        xfer = 1'b1;
                        if (r_owner == SLOT_NONE) begin
                            for (int i = 0; i < DEVICES; i++) begin
                                if (r_present[i] && r_state[i] != CS_INVALID) begin
                                    valid = OWNER_W'(i);
                                end
                            end
                        end
                    end else if (my_state == CS_SHARED) begin
                        for (int i = 0; i < DEVICES; i++) begin
                            if (r_present[i] && r_state[i] == CS_OWNED && r_newer[i]) begin
                                xfer  = 1'b1;
                                valid = OWNER_W'(i);
                            end
                        end
                    end
                    if (!r_item.want_read) begin
                        xfer = 1'b0;
                    end

                    if (xfer && valid[OWNER_W-1]) begin
                        n_result.status = STAT_NO_SOURCE;
                    end else begin
                        // Downgrade or drop the other copies, then update this one
                        for (int i = 0; i < DEVICES; i++) begin
                            s = r_state[i];
                            if (r_item.want_read && !sel[i] && r_present[i]
                                && s != CS_INVALID) begin
                                if (my_state == CS_OWNED && !r_item.want_write) begin
                                    drop_owner = 1'b1;
                                    if (r_older[i]) begin
                                        s = CS_INVALID;
                                    end
                                end
                                if (s == CS_EXCLUSIVE) begin
                                    s = CS_SHARED;
                                end
                            end
                            if (r_item.want_write && r_present[i] && s != CS_INVALID) begin
                                s = CS_SHARED;
                            end
                            if (sel[i]) begin
                                if (r_item.want_read) begin
                                    s = CS_SHARED;
                                    if (r_readers[i] != '1) begin
                                        n_readers[i] = r_readers[i] + RC_W'(1);
                                    end
                                end
                                if (r_item.want_write) begin
                                    s = CS_OWNED;
                                end
                            end
                            n_state[i] = s;
                        end
                        if (drop_owner) begin
                            n_owner = SLOT_NONE;
                        end
                        if (r_item.want_write) begin
                            n_owner = {1'b0, r_item.device};
                        end
                        if (xfer) begin
                            n_result.transfer_needed = 1'b1;
                            n_result.source_device   = valid;
                        end
                    end
                end
            end
            default: begin
                // Unknown action: no change, ok
                osel = '0;
            end
        endcase

        // Report the addressed slot after the action
        for (int i = 0; i < DEVICES; i++) begin
            if (osel[i] && n_present[i]) begin
                n_result.device_state = n_state[i];
            end
        end
        n_result.owner = n_owner;
    end

    // Control state of the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_owner   <= SLOT_NONE;
            for (int i = 0; i < DEVICES; i++) begin
                r_state[i] <= CS_INVALID;
            end
        end else if (i_cmd.commit) begin
            r_present <= n_present;
            r_owner   <= n_owner;
            r_state   <= n_state;
        end
    end

    // Payload: versions, reader counts, held transaction, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.compare) begin
            r_newer <= n_newer;
            r_older <= n_older;
        end
        if (i_cmd.commit) begin
            r_version <= n_version;
            r_readers <= n_readers;
            r_result  <= n_result;
        end
    end

    assign o_result = r_result;

    `MDCCD_ASSERT_IMP(a_owner_present, !r_owner[OWNER_W-1], r_present[r_owner[DEV_W-1:0]])

endmodule

[rtl/multi_device_copy_coherency_directory_core.sv]
// Top level of the multi-device copy coherency directory.
//
// Use: one directory entry for a datum copied across device slots.
// Input channel (s_axis): one transaction is one action. tuser carries the
// action code; tdata carries device, want_read, want_write and new_version.
// Output channel (m_axis): one result transaction for every input
// transaction, in order, carrying status, transfer flag, source slot,
// resulting slot state and owner.
// Timing: a transaction is taken in the capture phase, the slot versions
// are compared against the addressed slot in the compare phase, and the
// action is applied and its result registered in the commit phase. The
// result and its valid flag are registered together at commit; the block
// takes no new transaction until the current one is committed, following
// the capture / compare / commit sequence of the controller.
// Stall: a registered result waits for the sink; meanwhile the next
// transaction is held in the commit phase and no new one is accepted.
// Reset (synchronous, active low): no copies, all slots invalid, no owner,
// output empty.
module multi_device_copy_coherency_directory_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [2:0] device, [3] want_read, [4] want_write, [36:5] new_version
    input  logic [mdccd_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // [2:0] action
    input  logic [mdccd_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [1:0] status, [2] transfer_needed, [6:3] source_device,
    // [8:7] device_state, [12:9] owner
    output logic [mdccd_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);
    import mdccd_pkg::*;

    t_item   item;
    t_result result;
    t_dp_cmd cmd;

    // Unpack the incoming transaction
    always_comb begin
        item.action      = i_s_axis_tuser[2:0];
        item.device      = i_s_axis_tdata[2:0];
        item.want_read   = i_s_axis_tdata[3];
        item.want_write  = i_s_axis_tdata[4];
        item.new_version = i_s_axis_tdata[36:5];
    end

    mdccd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    mdccd_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (item),
        .o_result (result)
    );

    // Pack the result transaction
    assign o_m_axis_tdata = {3'b000, result.owner, result.device_state,
                             result.source_device, result.transfer_needed,
                             result.status};

endmodule
